[design/stc_pkg.sv]
// Package: shared types, codes and compare helpers of the sorted timer scheduler.
`default_nettype none
package stc_pkg;

    // Queue depth and field widths
    localparam int NUM_TIMERS = 16;
    localparam int TIMER_W    = 4;
    localparam int TIME_W     = 32;
    localparam int DELAY_W    = 31;

    // Request operation codes
    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_STOP   = 2'd1,
        OP_EXPIRE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_REPORT
    } state_t;

    // One queue entry
    typedef struct packed {
        logic               valid;
        logic [TIMER_W-1:0] timer;
        logic [TIME_W-1:0]  fire;
    } slot_t;

    localparam slot_t EMPTY_SLOT = '0;

    // Controls broadcast to every cell of the chain
    typedef struct packed {
        logic               rm_en;
        logic               pop;
        logic [TIMER_W-1:0] rm_id;
        logic               ins_en;
        logic [TIMER_W-1:0] ins_id;
        logic [TIME_W-1:0]  ins_fire;
        logic [TIME_W-1:0]  ins_now;
    } stc_ctrl_t;

    // a lies strictly before b on the wrapping time line
    function automatic logic strictly_before(input logic [TIME_W-1:0] a,
                                             input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] diff;
        diff = a - b;
        return diff[TIME_W-1];
    endfunction

    // Ordering relative to now: past-due entries sort first
    function automatic logic fires_before(input logic [TIME_W-1:0] fire_new,
                                          input logic [TIME_W-1:0] fire_cur,
                                          input logic [TIME_W-1:0] now);
        logic new_past;
        logic cur_past;
        new_past = strictly_before(fire_new, now);
        cur_past = strictly_before(fire_cur, now);
        if (new_past != cur_past)
            return new_past;
        return strictly_before(fire_new, fire_cur);
    endfunction

endpackage
`default_nettype wire

[design/stc_req_if.sv]
// Interface: request channel carrying one scheduler operation.
`default_nettype none
interface stc_req_if
    import stc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [TIMER_W-1:0] timer_id;
    logic [TIME_W-1:0]  base_time;
    logic [DELAY_W-1:0] delay;
    logic [TIME_W-1:0]  now;

    modport source (
        output valid, operation, timer_id, base_time, delay, now,
        input  ready
    );
    modport sink (
        input  valid, operation, timer_id, base_time, delay, now,
        output ready
    );
endinterface
`default_nettype wire

[design/stc_rsp_if.sv]
// Interface: result channel carrying fired timer and alarm setting.
`default_nettype none
interface stc_rsp_if
    import stc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               fired;
    logic [TIMER_W-1:0] fired_timer;
    logic               alarm_changed;
    logic               alarm_running;
    logic [TIME_W-1:0]  alarm_start;
    logic [TIME_W-1:0]  alarm_remaining;

    modport source (
        output valid, fired, fired_timer, alarm_changed, alarm_running,
               alarm_start, alarm_remaining,
        input  ready
    );
    modport sink (
        input  valid, fired, fired_timer, alarm_changed, alarm_running,
               alarm_start, alarm_remaining,
        output ready
    );
endinterface
`default_nettype wire

[design/sorted_timer_scheduler.sv]
// Top level: request sequencer, cell chain and registered result stage.
// Stop, alarm expiry and ignored requests go from acceptance via the report state to
// the result stage; a start first goes via an insert state that holds off requests:
// the chain does one shift pass per cycle (a removal, then an insertion). Throughput:
// 1 request per cycle for stop and expiry while the result stage is free.
// Reset: asynchronous, clears every cell at once (queue empty); no clearing pass.
`default_nettype none
module sorted_timer_scheduler
    import stc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    stc_req_if.sink   req,
    stc_rsp_if.source rsp
);

    state_t state_reg;
    state_t state_next;

    stc_ctrl_t ctrl;
    slot_t     head;
    logic      head_removed;
    logic      head_inserted;

    logic accept;
    logic out_free;
    logic report;
    logic id_ok;
    logic is_start;
    logic is_stop;
    logic is_expire;
    logic pop;

    // request context held through the insert and report cycles
    logic [TIME_W-1:0]  now_reg;
    logic [TIME_W-1:0]  fire_reg;
    logic [TIMER_W-1:0] id_reg;
    logic               changed_reg;
    logic               changed_next;
    logic               fired_reg;
    logic               fired_next;
    logic [TIMER_W-1:0] fired_id_reg;
    logic [TIMER_W-1:0] fired_id_next;

    // result stage
    logic               rsp_valid_reg;
    logic               rsp_fired_reg;
    logic [TIMER_W-1:0] rsp_fired_timer_reg;
    logic               rsp_changed_reg;
    logic               rsp_running_reg;
    logic [TIME_W-1:0]  rsp_start_reg;
    logic [TIME_W-1:0]  rsp_remaining_reg;
    logic               running;
    logic [TIME_W-1:0]  remaining;

    // request decode
    assign id_ok     = (32'(req.timer_id) < NUM_TIMERS);
    assign is_start  = (req.operation == OP_START) && id_ok;
    assign is_stop   = (req.operation == OP_STOP) && id_ok;
    assign is_expire = (req.operation == OP_EXPIRE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign report    = (state_reg == ST_REPORT) && out_free;

    // head due at expiry is popped
    assign pop = accept && is_expire && head.valid && !strictly_before(req.now, head.fire);

    // chain controls: removal on the accept edge, insertion in the insert cycle
    always_comb
    begin
        ctrl.rm_en    = accept && (is_start || is_stop);
        ctrl.pop      = pop;
        ctrl.rm_id    = req.timer_id;
        ctrl.ins_en   = (state_reg == ST_INSERT);
        ctrl.ins_id   = id_reg;
        ctrl.ins_fire = fire_reg;
        ctrl.ins_now  = now_reg;
    end

    stc_chain u_chain (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .head          (head),
        .head_removed  (head_removed),
        .head_inserted (head_inserted)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = is_start ? ST_INSERT : ST_REPORT;
            end
            ST_INSERT:
            begin
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    if (accept)
                        state_next = is_start ? ST_INSERT : ST_REPORT;
                    else
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        case (state_reg)
            ST_IDLE:   req.ready = 1'b1;
            ST_INSERT: req.ready = 1'b0;
            ST_REPORT: req.ready = out_free;
            default:   req.ready = 1'b0;
        endcase
    end

    // context flags
    always_comb
    begin
        changed_next  = changed_reg;
        fired_next    = fired_reg;
        fired_id_next = fired_id_reg;
        if (accept)
        begin
            changed_next  = head_removed || is_expire;
            fired_next    = pop;
            fired_id_next = pop ? head.timer : '0;
        end
        else if (state_reg == ST_INSERT)
        begin
            changed_next = changed_reg || head_inserted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            changed_reg  <= 1'b0;
            fired_reg    <= 1'b0;
            fired_id_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            changed_reg  <= changed_next;
            fired_reg    <= fired_next;
            fired_id_reg <= fired_id_next;
        end
    end

    // request payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg  <= req.now;
            fire_reg <= req.base_time + TIME_W'(req.delay);
            id_reg   <= req.timer_id;
        end
    end

    // alarm setting from the final head
    assign running   = changed_reg && head.valid;
    assign remaining = (running && strictly_before(now_reg, head.fire)) ?
                       (head.fire - now_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (report)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (report)
        begin
            rsp_fired_reg       <= fired_reg;
            rsp_fired_timer_reg <= fired_id_reg;
            rsp_changed_reg     <= changed_reg;
            rsp_running_reg     <= running;
            rsp_start_reg       <= running ? now_reg : '0;
            rsp_remaining_reg   <= remaining;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.fired           = rsp_fired_reg;
    assign rsp.fired_timer     = rsp_fired_timer_reg;
    assign rsp.alarm_changed   = rsp_changed_reg;
    assign rsp.alarm_running   = rsp_running_reg;
    assign rsp.alarm_start     = rsp_start_reg;
    assign rsp.alarm_remaining = rsp_remaining_reg;

endmodule
`default_nettype wire

[design/stc_cell.sv]
// Module: one queue cell holding a single entry, shifting with its neighbours.
`default_nettype none
module stc_cell
    import stc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire stc_ctrl_t ctrl,
    input  wire slot_t     left,
    input  wire slot_t     right,
    input  wire logic      rm_in,
    input  wire logic      ins_in,
    output slot_t          slot,
    output logic           rm_out,
    output logic           ins_out
);

    slot_t slot_reg;
    slot_t slot_next;
    logic  match;
    logic  ins_here;

    // removal: once a match is seen in this cell or upstream, it takes its right neighbour
    assign match  = ctrl.rm_en && slot_reg.valid && (slot_reg.timer == ctrl.rm_id);
    assign rm_out = rm_in | match;

    // insertion: first cell that sorts after the new entry takes it
    assign ins_here = ctrl.ins_en &&
                      (!slot_reg.valid ||
                       fires_before(ctrl.ins_fire, slot_reg.fire, ctrl.ins_now));
    assign ins_out  = ins_in | ins_here;

    always_comb
    begin
        slot_next = slot_reg;
        if (rm_out)
        begin
            slot_next = right;
        end
        else if (ins_in)
        begin
            slot_next = left;
        end
        else if (ins_here)
        begin
            slot_next.valid = 1'b1;
            slot_next.timer = ctrl.ins_id;
            slot_next.fire  = ctrl.ins_fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= EMPTY_SLOT;
        else
            slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule
`default_nettype wire

[design/stc_chain.sv]
// Module: row of queue cells with the removal and insertion shift chains.
`default_nettype none
module stc_chain
    import stc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire stc_ctrl_t ctrl,
    output slot_t          head,
    output logic           head_removed,
    output logic           head_inserted
);

    slot_t slots [NUM_TIMERS];
    logic  rm_chain  [NUM_TIMERS+1];
    logic  ins_chain [NUM_TIMERS+1];

    // a pop seeds the removal chain at the head
    assign rm_chain[0]  = ctrl.pop;
    assign ins_chain[0] = 1'b0;

    for (genvar i = 0; i < NUM_TIMERS; i++)
    begin : g_cell
        slot_t left_slot;
        slot_t right_slot;

        if (i == 0)
        begin : g_first
            assign left_slot = EMPTY_SLOT;
        end
        else
        begin : g_mid_l
            assign left_slot = slots[i-1];
        end

        if (i == NUM_TIMERS-1)
        begin : g_last
            assign right_slot = EMPTY_SLOT;
        end
        else
        begin : g_mid_r
            assign right_slot = slots[i+1];
        end

        stc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .left    (left_slot),
            .right   (right_slot),
            .rm_in   (rm_chain[i]),
            .ins_in  (ins_chain[i]),
            .slot    (slots[i]),
            .rm_out  (rm_chain[i+1]),
            .ins_out (ins_chain[i+1])
        );
    end

    assign head          = slots[0];
    assign head_removed  = rm_chain[1];
    assign head_inserted = ins_chain[1];

endmodule
`default_nettype wire
